/* rtl/core/rsc_pkg.sv */
// Shared widths and types for the ray versus wall segment cast pipeline.
// Used by the channel interfaces, the divider step and the top level.
package rsc_pkg;

  localparam int unsigned T_FRAC_BITS = 16;
  localparam int unsigned DIR_FRAC    = 14;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned DIR_W       = 16;
  localparam int unsigned LEN_W       = 23;
  localparam int unsigned LIM_W       = 20;
  localparam int unsigned CFG_W       = 23;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned VEC_W       = 26;
  localparam int unsigned PRE_W       = DIR_W + LEN_W + 1;
  localparam int unsigned PROD_W      = VEC_W + DIFF_W;
  localparam int unsigned CROSS_W     = PROD_W + 1;
  localparam int unsigned NUM_W       = CROSS_W + 1;
  localparam int unsigned QUO_W       = T_FRAC_BITS + 1;
  localparam int unsigned TP_W        = QUO_W + 1 + VEC_W;
  localparam int unsigned LP_W        = QUO_W + LEN_W;

  typedef enum logic {
    REG_RAY_LENGTH     = 1'b0,
    REG_PARALLEL_LIMIT = 1'b1
  } rsc_reg_e;

  // Item state while the quotient t is being developed.
  typedef struct packed {
    logic                     hit;
    logic [NUM_W-1:0]         num;
    logic [CROSS_W-1:0]       dmag;
    logic [QUO_W-1:0]         quo;
    logic signed [VEC_W-1:0]  dx;
    logic signed [VEC_W-1:0]  dy;
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
  } rsc_div_t;

endpackage

/* rtl/core/rsc_if.sv */
// Valid/ready channel interfaces for cast items and cast results.
// Depends on rsc_pkg for field widths.
interface rsc_item_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::COORD_W-1:0]  ray_x;
  logic signed [rsc_pkg::COORD_W-1:0]  ray_y;
  logic signed [rsc_pkg::DIR_W-1:0]    dir_x;
  logic signed [rsc_pkg::DIR_W-1:0]    dir_y;
  logic signed [rsc_pkg::COORD_W-1:0]  wall_ax;
  logic signed [rsc_pkg::COORD_W-1:0]  wall_ay;
  logic signed [rsc_pkg::COORD_W-1:0]  wall_bx;
  logic signed [rsc_pkg::COORD_W-1:0]  wall_by;

  modport source (output valid, ray_x, ray_y, dir_x, dir_y, wall_ax, wall_ay, wall_bx,
                  wall_by, input ready);
  modport sink (input valid, ray_x, ray_y, dir_x, dir_y, wall_ax, wall_ay, wall_bx,
                wall_by, output ready);
endinterface

interface rsc_result_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [rsc_pkg::COORD_W-1:0]  hit_x;
  logic signed [rsc_pkg::COORD_W-1:0]  hit_y;
  logic [rsc_pkg::LEN_W-1:0]           hit_distance;

  modport source (output valid, hit, hit_x, hit_y, hit_distance, input ready);
  modport sink (input valid, hit, hit_x, hit_y, hit_distance, output ready);
endinterface

/* rtl/core/rsc_div_step.sv */
// One registered step of the restoring divider that forms t = |tn| / |D|.
// Depends on rsc_pkg for the rsc_div_t item record.
module rsc_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rsc_pkg::rsc_div_t data_i,
  output logic              valid_o,
  output rsc_pkg::rsc_div_t data_o
);

  logic [rsc_pkg::NUM_W-1:0] shifted;
  logic [rsc_pkg::NUM_W-1:0] divisor;
  logic                      ge;
  rsc_pkg::rsc_div_t         next;

  always_comb begin
    shifted  = {data_i.num[rsc_pkg::NUM_W-2:0], 1'b0};
    divisor  = {1'b0, data_i.dmag};
    ge       = shifted >= divisor;
    next     = data_i;
    next.num = ge ? (shifted - divisor) : shifted;
    next.quo = {data_i.quo[rsc_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= next;
    end
  end

endmodule

/* rtl/core/ray_segment_cast_top.sv */
// Ray segment versus wall segment cast, fully pipelined.
// Depends on rsc_pkg, rsc_if (rsc_item_if, rsc_result_if) and rsc_div_step.
//
//   channel   direction  handshake          payload
//   item_i    in         valid/ready        ray origin, direction, wall endpoints
//   result_o  out        valid/ready        hit, hit_x, hit_y, hit_distance
//   cfg       in         cfg_we_i, no ready cfg_idx_i, cfg_data_i
//
// One item enters every cycle unless the pipeline holds. The depth is set by the
// 17 compare-subtract stages of the quotient divider plus the multiply stages.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds when the output register is full and not taken.
module ray_segment_cast_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [rsc_pkg::CFG_W-1:0]   cfg_data_i,
  rsc_item_if.sink                    item_i,
  rsc_result_if.source                result_o
);

  localparam int unsigned CW = rsc_pkg::COORD_W;
  localparam int unsigned DW = rsc_pkg::DIFF_W;
  localparam int unsigned VW = rsc_pkg::VEC_W;
  localparam int unsigned PW = rsc_pkg::PROD_W;
  localparam int unsigned XW = rsc_pkg::CROSS_W;
  localparam int unsigned TF = rsc_pkg::T_FRAC_BITS;
  localparam int unsigned SW = rsc_pkg::TP_W - TF + 1;
  localparam int unsigned LS = rsc_pkg::LP_W + 1 - TF;

  logic [rsc_pkg::LEN_W-1:0] len_q;
  logic [rsc_pkg::LIM_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= rsc_pkg::LEN_W'(4096000);
      limit_q <= rsc_pkg::LIM_W'(2);
    end else if (cfg_we_i) begin
      unique case (rsc_pkg::rsc_reg_e'(cfg_idx_i))
        rsc_pkg::REG_RAY_LENGTH:     len_q   <= cfg_data_i[rsc_pkg::LEN_W-1:0];
        rsc_pkg::REG_PARALLEL_LIMIT: limit_q <= cfg_data_i[rsc_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en           = !result_o.valid || result_o.ready;
  assign item_i.ready = en;

  // Stage 1: ray direction times length, wall vector and offset.
  logic                          s1_v_q;
  logic signed [rsc_pkg::PRE_W-1:0] s1_pdx_q, s1_pdy_q;
  logic signed [DW-1:0]          s1_sx_q, s1_sy_q, s1_wx_q, s1_wy_q;
  logic signed [CW-1:0]          s1_ox_q, s1_oy_q;
  // Stage 2: rounded ray vector.
  logic                          s2_v_q;
  logic signed [VW-1:0]          s2_dx_q, s2_dy_q;
  logic signed [DW-1:0]          s2_sx_q, s2_sy_q, s2_wx_q, s2_wy_q;
  logic signed [CW-1:0]          s2_ox_q, s2_oy_q;
  // Stage 3: cross products.
  logic                          s3_v_q;
  logic signed [PW-1:0]          s3_a_q, s3_b_q, s3_c_q, s3_d_q, s3_e_q, s3_f_q;
  logic signed [VW-1:0]          s3_dx_q, s3_dy_q;
  logic signed [CW-1:0]          s3_ox_q, s3_oy_q;
  // Stage 4: denominator and numerators.
  logic                          s4_v_q;
  logic signed [XW-1:0]          s4_den_q, s4_tn_q, s4_un_q;
  logic signed [VW-1:0]          s4_dx_q, s4_dy_q;
  logic signed [CW-1:0]          s4_ox_q, s4_oy_q;
  // Stage 5: magnitudes, signs and zero flags.
  logic                          s5_v_q;
  logic [XW-1:0]                 s5_dmag_q, s5_tmag_q, s5_umag_q;
  logic                          s5_ds_q, s5_ts_q, s5_us_q, s5_dz_q, s5_tz_q, s5_uz_q;
  logic signed [VW-1:0]          s5_dx_q, s5_dy_q;
  logic signed [CW-1:0]          s5_ox_q, s5_oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= item_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pdx_q <= item_i.dir_x * $signed({1'b0, len_q});
      s1_pdy_q <= item_i.dir_y * $signed({1'b0, len_q});
      s1_sx_q  <= DW'(item_i.wall_bx) - DW'(item_i.wall_ax);
      s1_sy_q  <= DW'(item_i.wall_by) - DW'(item_i.wall_ay);
      s1_wx_q  <= DW'(item_i.wall_ax) - DW'(item_i.ray_x);
      s1_wy_q  <= DW'(item_i.wall_ay) - DW'(item_i.ray_y);
      s1_ox_q  <= item_i.ray_x;
      s1_oy_q  <= item_i.ray_y;

      s2_dx_q <= VW'((s1_pdx_q + rsc_pkg::PRE_W'(1 << (rsc_pkg::DIR_FRAC - 1)))
                     >>> rsc_pkg::DIR_FRAC);
      s2_dy_q <= VW'((s1_pdy_q + rsc_pkg::PRE_W'(1 << (rsc_pkg::DIR_FRAC - 1)))
                     >>> rsc_pkg::DIR_FRAC);
      s2_sx_q <= s1_sx_q;
      s2_sy_q <= s1_sy_q;
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
      s2_ox_q <= s1_ox_q;
      s2_oy_q <= s1_oy_q;

      s3_a_q  <= s2_dx_q * s2_sy_q;
      s3_b_q  <= s2_dy_q * s2_sx_q;
      s3_c_q  <= s2_wx_q * s2_sy_q;
      s3_d_q  <= s2_wy_q * s2_sx_q;
      s3_e_q  <= s2_wx_q * s2_dy_q;
      s3_f_q  <= s2_wy_q * s2_dx_q;
      s3_dx_q <= s2_dx_q;
      s3_dy_q <= s2_dy_q;
      s3_ox_q <= s2_ox_q;
      s3_oy_q <= s2_oy_q;

      s4_den_q <= XW'(s3_a_q) - XW'(s3_b_q);
      s4_tn_q  <= XW'(s3_c_q) - XW'(s3_d_q);
      s4_un_q  <= XW'(s3_e_q) - XW'(s3_f_q);
      s4_dx_q  <= s3_dx_q;
      s4_dy_q  <= s3_dy_q;
      s4_ox_q  <= s3_ox_q;
      s4_oy_q  <= s3_oy_q;

      s5_dmag_q <= s4_den_q[XW-1] ? XW'(-s4_den_q) : XW'(s4_den_q);
      s5_tmag_q <= s4_tn_q[XW-1] ? XW'(-s4_tn_q) : XW'(s4_tn_q);
      s5_umag_q <= s4_un_q[XW-1] ? XW'(-s4_un_q) : XW'(s4_un_q);
      s5_ds_q   <= s4_den_q[XW-1];
      s5_ts_q   <= s4_tn_q[XW-1];
      s5_us_q   <= s4_un_q[XW-1];
      s5_dz_q   <= s4_den_q == '0;
      s5_tz_q   <= s4_tn_q == '0;
      s5_uz_q   <= s4_un_q == '0;
      s5_dx_q   <= s4_dx_q;
      s5_dy_q   <= s4_dy_q;
      s5_ox_q   <= s4_ox_q;
      s5_oy_q   <= s4_oy_q;
    end
  end

  // Stage 6: hit decision and the integer bit of t. A numerator of zero is in
  // range; otherwise its sign must match D and its magnitude stay within |D|.
  logic              parallel, t_in, u_in;
  logic [rsc_pkg::NUM_W-1:0] num0, div0;
  logic              ge0;
  rsc_pkg::rsc_div_t div_first;

  always_comb begin
    parallel = s5_dz_q || (s5_dmag_q < XW'(limit_q));
    t_in     = s5_tz_q || ((s5_ts_q == s5_ds_q) && (s5_tmag_q <= s5_dmag_q));
    u_in     = s5_uz_q || ((s5_us_q == s5_ds_q) && (s5_umag_q <= s5_dmag_q));
    num0     = {1'b0, s5_tmag_q};
    div0     = {1'b0, s5_dmag_q};
    ge0      = num0 >= div0;
    div_first.hit  = !parallel && t_in && u_in;
    div_first.num  = ge0 ? (num0 - div0) : num0;
    div_first.dmag = s5_dmag_q;
    div_first.quo  = rsc_pkg::QUO_W'(ge0);
    div_first.dx   = s5_dx_q;
    div_first.dy   = s5_dy_q;
    div_first.ox   = s5_ox_q;
    div_first.oy   = s5_oy_q;
  end

  logic              div_v[0:TF];
  rsc_pkg::rsc_div_t div_d[0:TF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v[0] <= 1'b0;
    end else if (en) begin
      div_v[0] <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_d[0] <= div_first;
    end
  end

  for (genvar k = 0; k < TF; k++) begin : g_div
    rsc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[k]),
      .data_i  (div_d[k]),
      .valid_o (div_v[k+1]),
      .data_o  (div_d[k+1])
    );
  end

  // Scale stage: t times the ray vector and the length.
  logic                             m_v_q, m_hit_q;
  logic signed [rsc_pkg::TP_W-1:0]  m_px_q, m_py_q;
  logic [rsc_pkg::LP_W-1:0]         m_pl_q;
  logic signed [CW-1:0]             m_ox_q, m_oy_q;
  logic signed [rsc_pkg::QUO_W:0]   t_s;

  assign t_s = $signed({1'b0, div_d[TF].quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q           <= 1'b0;
      result_o.valid  <= 1'b0;
    end else if (en) begin
      m_v_q           <= div_v[TF];
      result_o.valid  <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_hit_q <= div_d[TF].hit;
      m_px_q  <= t_s * div_d[TF].dx;
      m_py_q  <= t_s * div_d[TF].dy;
      m_pl_q  <= div_d[TF].quo * len_q;
      m_ox_q  <= div_d[TF].ox;
      m_oy_q  <= div_d[TF].oy;
    end
  end

  // Output stage: round half up, add the origin, saturate and zero the fields on a miss.
  localparam logic signed [SW-1:0] SMAX = SW'(8388607);
  localparam logic signed [SW-1:0] SMIN = -SW'(8388608);

  logic signed [rsc_pkg::TP_W-1:0] rx_full, ry_full;
  logic signed [SW-1:0]            sum_x, sum_y;
  logic [rsc_pkg::LP_W:0]          rl_full;
  logic [LS-1:0]                   dist_rnd;
  logic signed [CW-1:0]            hx, hy;
  logic [rsc_pkg::LEN_W-1:0]       hd;

  always_comb begin
    rx_full = (m_px_q + rsc_pkg::TP_W'(1 << (TF - 1))) >>> TF;
    ry_full = (m_py_q + rsc_pkg::TP_W'(1 << (TF - 1))) >>> TF;
    sum_x   = SW'(m_ox_q) + SW'(rx_full);
    sum_y   = SW'(m_oy_q) + SW'(ry_full);
    rl_full = ({1'b0, m_pl_q} + (rsc_pkg::LP_W + 1)'(1 << (TF - 1))) >> TF;
    dist_rnd = rl_full[LS-1:0];
    if (sum_x > SMAX)      hx = CW'(SMAX);
    else if (sum_x < SMIN) hx = CW'(SMIN);
    else                   hx = CW'(sum_x);
    if (sum_y > SMAX)      hy = CW'(SMAX);
    else if (sum_y < SMIN) hy = CW'(SMIN);
    else                   hy = CW'(sum_y);
    if (dist_rnd > LS'(8388607)) hd = rsc_pkg::LEN_W'(8388607);
    else                         hd = dist_rnd[rsc_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_o.hit          <= m_hit_q;
      result_o.hit_x        <= m_hit_q ? hx : '0;
      result_o.hit_y        <= m_hit_q ? hy : '0;
      result_o.hit_distance <= m_hit_q ? hd : '0;
    end
  end

endmodule
